[hw/rtl/ffba_pkg.sv]
// shared types and constants for the first-fit block allocator
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int ADDR_W       = 24;
    localparam int HEADER_BYTES = 24;
    localparam int ALIGN_SH     = 4;
    localparam int ENT_W        = ADDR_W + 1;

    localparam logic [ADDR_W-1:0] HEAP_RESET = 24'd1048576;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FAIL    = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_PROC,
        S_A_TAIL,
        S_F_RD,
        S_F_PROC,
        S_M_RD,
        S_M_PROC,
        S_M_FLUSH,
        S_COMMIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic rd;
        logic a_proc;
        logic a_tail;
        logic f_proc;
        logic m_proc;
        logic m_flush;
        logic commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_mode;
        logic in_zero;
        logic in_null;
        logic at_end;
        logic split;
        logic match;
        logic found;
        logic out_free;
    } sts_t;

endpackage

[hw/rtl/ffba_ctrl.sv]
// controller state machine for the allocator scans
module ffba_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  ffba_pkg::sts_t sts,
    output ffba_pkg::cmd_t cmd
);
    import ffba_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (!sts.in_mode) begin
                        state_next = sts.in_zero ? S_DONE : S_A_RD;
                    end else begin
                        state_next = sts.in_null ? S_DONE : S_F_RD;
                    end
                end
            end
            S_A_RD: begin
                if (sts.at_end) begin
                    state_next = sts.found ? S_COMMIT : S_DONE;
                end else begin
                    state_next = S_A_PROC;
                end
            end
            S_A_PROC:  state_next = sts.split ? S_A_TAIL : S_A_RD;
            S_A_TAIL:  state_next = S_A_RD;
            S_F_RD:    state_next = sts.at_end ? S_DONE : S_F_PROC;
            S_F_PROC:  state_next = sts.match ? S_M_RD : S_F_RD;
            S_M_RD:    state_next = sts.at_end ? S_M_FLUSH : S_M_PROC;
            S_M_PROC:  state_next = S_M_RD;
            S_M_FLUSH: state_next = S_COMMIT;
            S_COMMIT:  state_next = S_DONE;
            S_DONE:    state_next = sts.out_free ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            S_A_RD, S_F_RD, S_M_RD: cmd.rd = !sts.at_end;
            S_A_PROC:  cmd.a_proc = 1'b1;
            S_A_TAIL:  cmd.a_tail = 1'b1;
            S_F_PROC:  cmd.f_proc = 1'b1;
            S_M_PROC:  cmd.m_proc = 1'b1;
            S_M_FLUSH: cmd.m_flush = 1'b1;
            S_COMMIT:  cmd.commit = 1'b1;
            S_DONE:    cmd.out_load = sts.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

[hw/rtl/ffba_dpath.sv]
// block table memory, scan registers and result register
module ffba_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ffba_pkg::cmd_t               cmd,
    output ffba_pkg::sts_t               sts,
    input  logic                         in_mode,
    input  logic [ffba_pkg::ADDR_W-1:0]  in_size,
    input  logic [ffba_pkg::ADDR_W-1:0]  in_addr,
    input  logic [ffba_pkg::ADDR_W-1:0]  heap_bytes,
    input  logic                         cfg_wr,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ffba_pkg::status_t            m_status,
    output logic [ffba_pkg::ADDR_W-1:0]  m_grant_address,
    output logic [ffba_pkg::ADDR_W-1:0]  m_grant_bytes
);
    import ffba_pkg::*;

    logic [ENT_W-1:0] mem [2*MAX_BLOCKS];
    logic [ENT_W-1:0] rdata_reg;

    logic              bank_reg, init_reg;
    logic [CNT_W-1:0]  count_reg, idx_reg, wptr_reg;
    logic [ADDR_W-1:0] cur_start_reg, addr_reg, tail_len_reg, pend_len_reg;
    logic [ADDR_W:0]   need_reg;
    logic              found_reg, pend_valid_reg, pend_free_reg;
    logic [IDX_W-1:0]  tgt_reg;
    status_t           res_status_reg;
    logic [ADDR_W-1:0] res_addr_reg, res_bytes_reg;

    logic              e_free, ef, fit, split_ok, we;
    logic [ADDR_W-1:0] e_len, init_len, start_next;
    logic [ADDR_W:0]   rest, start_hdr, need_in;
    logic [ENT_W-1:0]  wdata;

    assign init_len   = (heap_bytes >= ADDR_W'(HEADER_BYTES)) ?
                        heap_bytes - ADDR_W'(HEADER_BYTES) : '0;
    assign e_free     = (init_reg && idx_reg == '0) ? 1'b1 : rdata_reg[ADDR_W];
    assign e_len      = (init_reg && idx_reg == '0) ? init_len : rdata_reg[ADDR_W-1:0];
    assign need_in    = (({1'b0, in_size} + (ENT_W)'((1 << ALIGN_SH) - 1)) >> ALIGN_SH)
                        << ALIGN_SH;
    assign fit        = !found_reg && e_free && ({1'b0, e_len} >= need_reg);
    assign rest       = {1'b0, e_len} - need_reg;
    assign split_ok   = fit && (rest > (ENT_W)'(HEADER_BYTES + (1 << ALIGN_SH)))
                        && (count_reg < CNT_W'(MAX_BLOCKS));
    assign start_hdr  = {1'b0, cur_start_reg} + (ENT_W)'(HEADER_BYTES);
    assign start_next = cur_start_reg + ADDR_W'(HEADER_BYTES) + e_len;
    assign ef         = e_free || (idx_reg[IDX_W-1:0] == tgt_reg);

    always_comb begin
        we    = 1'b0;
        wdata = {e_free, e_len};
        if (cmd.a_proc) begin
            we = 1'b1;
            if (fit) begin
                wdata = {1'b0, split_ok ? need_reg[ADDR_W-1:0] : e_len};
            end
        end else if (cmd.a_tail) begin
            we    = 1'b1;
            wdata = {1'b1, tail_len_reg};
        end else if (cmd.m_proc) begin
            we    = pend_valid_reg && !(pend_free_reg && ef);
            wdata = {pend_free_reg, pend_len_reg};
        end else if (cmd.m_flush) begin
            we    = pend_valid_reg;
            wdata = {pend_free_reg, pend_len_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[{!bank_reg, wptr_reg[IDX_W-1:0]}] <= wdata;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[{bank_reg, idx_reg[IDX_W-1:0]}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg  <= 1'b0;
            init_reg  <= 1'b1;
            count_reg <= CNT_W'(1);
            m_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                init_reg  <= 1'b1;
                count_reg <= CNT_W'(1);
            end else if (cmd.commit) begin
                bank_reg  <= !bank_reg;
                init_reg  <= 1'b0;
                count_reg <= wptr_reg;
            end
            if (cmd.out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            wptr_reg <= wptr_reg + CNT_W'(1);
        end
        if (cmd.start) begin
            need_reg       <= need_in;
            addr_reg       <= in_addr;
            idx_reg        <= '0;
            wptr_reg       <= '0;
            cur_start_reg  <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_addr_reg   <= '0;
            res_bytes_reg  <= '0;
            if (!in_mode) begin
                res_status_reg <= ST_FAIL;
            end else begin
                res_status_reg <= (in_addr == '0) ? ST_OK : ST_UNKNOWN;
            end
        end
        if (cmd.a_proc) begin
            idx_reg       <= idx_reg + CNT_W'(1);
            cur_start_reg <= start_next;
            if (fit) begin
                found_reg      <= 1'b1;
                res_status_reg <= ST_OK;
                res_addr_reg   <= start_hdr[ADDR_W-1:0];
                res_bytes_reg  <= split_ok ? need_reg[ADDR_W-1:0] : e_len;
                tail_len_reg   <= rest[ADDR_W-1:0] - ADDR_W'(HEADER_BYTES);
            end
        end
        if (cmd.f_proc) begin
            if (start_hdr == {1'b0, addr_reg}) begin
                tgt_reg        <= idx_reg[IDX_W-1:0];
                res_status_reg <= ST_OK;
                idx_reg        <= '0;
                cur_start_reg  <= '0;
                wptr_reg       <= '0;
            end else begin
                idx_reg       <= idx_reg + CNT_W'(1);
                cur_start_reg <= start_next;
            end
        end
        if (cmd.m_proc) begin
            idx_reg <= idx_reg + CNT_W'(1);
            if (pend_valid_reg && pend_free_reg && ef) begin
                pend_len_reg <= pend_len_reg + ADDR_W'(HEADER_BYTES) + e_len;
            end else begin
                pend_valid_reg <= 1'b1;
                pend_free_reg  <= ef;
                pend_len_reg   <= e_len;
            end
        end
        if (cmd.out_load) begin
            m_status        <= res_status_reg;
            m_grant_address <= res_addr_reg;
            m_grant_bytes   <= res_bytes_reg;
        end
    end

    always_comb begin
        sts          = '0;
        sts.in_mode  = in_mode;
        sts.in_zero  = (in_size == '0);
        sts.in_null  = (in_addr == '0);
        sts.at_end   = (idx_reg == count_reg);
        sts.split    = split_ok;
        sts.match    = (start_hdr == {1'b0, addr_reg});
        sts.found    = found_reg;
        sts.out_free = !m_valid || m_ready;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 && count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count out of range");
    a_wptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> wptr_reg < CNT_W'(MAX_BLOCKS))
        else $error("table write beyond last entry");
    a_commit_clears_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !cfg_wr) |=> !init_reg)
        else $error("initial table flag kept after commit");
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result not presented after load");

endmodule

[hw/rtl/first_fit_block_allocator.sv]
// first-fit block allocator top level with configuration port
// allocate: reads then processes each entry, adds a tail entry on a split, commits on a fit
// free: scans up to the match, then a merge pass, a flush and a commit (unknown: scan only)
// zero size and null free skip the scan; a stalled output holds the done state until free
// throughput: one word at a time, next word taken the cycle after the result is loaded
// reset: heap_bytes returns to 1048576 and the table holds one free block, no clearing pass
module first_fit_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // request_size, block_address
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // grant_address, grant_bytes
    output logic [1:0]  m_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffba_pkg::*;

    logic [ADDR_W-1:0] heap_reg;
    logic              cfg_wr;
    cmd_t              cmd;
    sts_t              sts;
    status_t           m_status;
    logic [ADDR_W-1:0] m_grant_address, m_grant_bytes;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {8'd0, heap_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_reg <= HEAP_RESET;
        end else if (cfg_wr) begin
            heap_reg <= pwdata[ADDR_W-1:0];
        end
    end

    ffba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffba_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_mode         (s_tuser[0]),
        .in_size         (s_tdata[23:0]),
        .in_addr         (s_tdata[47:24]),
        .heap_bytes      (heap_reg),
        .cfg_wr          (cfg_wr),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .m_status        (m_status),
        .m_grant_address (m_grant_address),
        .m_grant_bytes   (m_grant_bytes)
    );

    assign m_tdata = {m_grant_bytes, m_grant_address};
    assign m_tuser = m_status;

endmodule

[sim/first_fit_block_allocator_tb.sv]
// self-checking testbench for the first-fit block allocator with a block table predictor
module first_fit_block_allocator_tb;
    import ffba_pkg::*;

    typedef struct packed {
        logic        mode;
        logic [23:0] size;
        logic [23:0] addr;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [23:0] gaddr;
        logic [23:0] gbytes;
    } grant_t;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;
    localparam logic [2:0] REG_HEAP_BYTES = 3'd0;
    localparam int CYCLE_LIMIT = 20000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // request_size, block_address
    logic [0:0]  s_tuser = '0;   // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // grant_address, grant_bytes
    logic [1:0]  m_tuser;        // status
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    first_fit_block_allocator uut (.*);

    always #2 aclk = ~aclk;

    // predictor state
    logic [23:0] tbl_start [MAX_BLOCKS];
    logic [23:0] tbl_len [MAX_BLOCKS];
    logic        tbl_free [MAX_BLOCKS];
    int          tbl_count;
    logic [23:0] heap_size;

    req_t   pending_words[$];
    grant_t expected_grants[$];
    logic [23:0] live_addrs[$];
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  errors = 0;
    int  cycles = 0;

    function automatic void reset_table();
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            tbl_start[i] = '0;
            tbl_len[i] = '0;
            tbl_free[i] = 1'b0;
        end
        tbl_len[0] = heap_size >= 24'(HEADER_BYTES) ? heap_size - 24'(HEADER_BYTES) : '0;
        tbl_free[0] = 1'b1;
        tbl_count = 1;
    endfunction

    function automatic grant_t predict_grant(req_t r);
        grant_t g;
        logic [24:0] need;
        logic [23:0] rest;
        int i;
        int j;
        g.status = ST_OK;
        g.gaddr = '0;
        g.gbytes = '0;
        if (r.mode == MODE_ALLOC) begin
            if (r.size == 0) begin
                g.status = ST_FAIL;
                return g;
            end
            need = ({1'b0, r.size} + 25'd15) & ~25'd15;
            for (i = 0; i < tbl_count; i++) begin
                if (tbl_free[i] && {1'b0, tbl_len[i]} >= need) begin
                    rest = tbl_len[i] - need[23:0];
                    if (rest > HEADER_BYTES + 16 && tbl_count < MAX_BLOCKS) begin
                        for (j = tbl_count; j > i + 1; j--) begin
                            tbl_start[j] = tbl_start[j-1];
                            tbl_len[j] = tbl_len[j-1];
                            tbl_free[j] = tbl_free[j-1];
                        end
                        tbl_start[i+1] = tbl_start[i] + 24'(HEADER_BYTES) + need[23:0];
                        tbl_len[i+1] = rest - 24'(HEADER_BYTES);
                        tbl_free[i+1] = 1'b1;
                        tbl_count++;
                        tbl_len[i] = need[23:0];
                    end
                    tbl_free[i] = 1'b0;
                    g.gaddr = tbl_start[i] + 24'(HEADER_BYTES);
                    g.gbytes = tbl_len[i];
                    return g;
                end
            end
            g.status = ST_FAIL;
            return g;
        end
        if (r.addr == 0) return g;
        for (i = 0; i < tbl_count; i++)
            if ({1'b0, tbl_start[i]} + 25'(HEADER_BYTES) == {1'b0, r.addr}) break;
        if (i >= tbl_count) begin
            g.status = ST_UNKNOWN;
            return g;
        end
        tbl_free[i] = 1'b1;
        for (i = 0; i < tbl_count; i++) begin
            while (tbl_free[i] && i + 1 < tbl_count && tbl_free[i+1]) begin
                tbl_len[i] = tbl_len[i] + 24'(HEADER_BYTES) + tbl_len[i+1];
                for (j = i + 1; j + 1 < tbl_count; j++) begin
                    tbl_start[j] = tbl_start[j+1];
                    tbl_len[j] = tbl_len[j+1];
                    tbl_free[j] = tbl_free[j+1];
                end
                tbl_count--;
            end
        end
        return g;
    endfunction

    // driver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_t r;
                    r = pending_words.pop_front();
                    expected_grants.push_back(predict_grant(r));
                    s_tvalid <= 1'b1;
                    s_tdata <= {r.addr, r.size};
                    s_tuser <= r.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected word status=%0d", m_tuser);
                errors++;
            end else begin
                grant_t e;
                e = expected_grants.pop_front();
                if (m_tuser !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_tuser);
                    errors++;
                end
                if (m_tdata[23:0] !== e.gaddr) begin
                    $error("grant_address exp %0h got %0h", e.gaddr, m_tdata[23:0]);
                    errors++;
                end
                if (m_tdata[47:24] !== e.gbytes) begin
                    $error("grant_bytes exp %0h got %0h", e.gbytes, m_tdata[47:24]);
                    errors++;
                end
                if (e.status == ST_OK && e.gaddr != 0) live_addrs.push_back(e.gaddr);
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_word(logic mode, logic [23:0] size, logic [23:0] addr);
        req_t r;
        r.mode = mode;
        r.size = size;
        r.addr = addr;
        pending_words.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_tvalid || expected_grants.size() > 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_heap(logic [23:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_HEAP_BYTES;
        pwdata <= {8'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        heap_size = val;
        reset_table();
        live_addrs.delete();
    endtask

    task automatic random_words(int n, logic [23:0] max_size);
        int k;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: push_word(MODE_ALLOC, 24'($urandom_range(max_size, 1)),
                                      24'($urandom));
                4: push_word(MODE_ALLOC, 24'($urandom), 24'($urandom));
                5, 6, 7: begin
                    // free a granted block if one is live, after waiting for outstanding grants so its address is known
                    wait_drained();
                    if (live_addrs.size() > 0) begin
                        k = $urandom_range(live_addrs.size() - 1);
                        push_word(MODE_FREE, 24'($urandom), live_addrs[k]);
                        live_addrs.delete(k);
                    end else begin
                        push_word(MODE_FREE, 24'($urandom), 24'($urandom));
                    end
                end
                8: push_word(MODE_FREE, 24'($urandom), 24'($urandom));
                default: push_word(MODE_FREE, 24'($urandom), 24'd0);
            endcase
        end
        wait_drained();
    endtask

    initial begin
        heap_size = HEAP_RESET;
        reset_table();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 7;
        recv_idle_pct = 76;
        // directed
        push_word(MODE_ALLOC, 24'd0, 24'hffffff);
        push_word(MODE_ALLOC, 24'd1, 24'd0);
        push_word(MODE_ALLOC, 24'd17, 24'd0);
        push_word(MODE_ALLOC, 24'hffffff, 24'd0);
        push_word(MODE_ALLOC, 24'd100, 24'd0);
        push_word(MODE_FREE, 24'hffffff, 24'd0);
        push_word(MODE_FREE, 24'd0, 24'd24);
        push_word(MODE_FREE, 24'd0, 24'd24);
        push_word(MODE_FREE, 24'd0, 24'hffffff);
        push_word(MODE_FREE, 24'd0, 24'd64);
        push_word(MODE_FREE, 24'd0, 24'd7);
        for (int i = 0; i < 70; i++) push_word(MODE_ALLOC, 24'd16, 24'd0);
        wait_drained();
        write_heap(24'd64);
        push_word(MODE_ALLOC, 24'd40, 24'd0);
        push_word(MODE_ALLOC, 24'd41, 24'd0);
        push_word(MODE_FREE, 24'd0, 24'd24);
        push_word(MODE_ALLOC, 24'd1, 24'd0);
        wait_drained();
        write_heap(24'd10);
        push_word(MODE_ALLOC, 24'd1, 24'd0);
        wait_drained();
        write_heap(24'd4096);
        random_words(500, 24'd300);
        send_idle_pct = 76;
        recv_idle_pct = 7;
        write_heap(24'hffffff);
        random_words(500, 24'd400000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_heap(24'd2000);
        random_words(500, 24'd200);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[first_fit_block_allocator.f]
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/ffba_dpath.sv
hw/rtl/first_fit_block_allocator.sv
sim/first_fit_block_allocator_tb.sv
